>>> sv/ep2y_pkg.sv
// Package for the epoch-seconds-to-year/time converter.
// Shared widths, constants and the structs passed between the datapath modules.
// No dependencies.
package ep2y_pkg;

	localparam int SUB_W   = 18;  // shared subtractor width, holds one day of seconds
	localparam int YEAR_W  = 12;
	localparam int DAYS_W  = 16;  // whole days below 2^32/86400
	localparam int MUL_A_W = 25;  // seconds >> 7
	localparam int MUL_B_W = 26;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	// floor(x / d) == (x * ceil(2^s / d)) >> s over the operand ranges used here;
	// the powers of two in 86400, 3600 and 60 are shifted off the operand first
	localparam int DAY_SHIFT  = 35;
	localparam int HOUR_SHIFT = 21;
	localparam int MIN_SHIFT  = 14;

	localparam logic [MUL_B_W-1:0] DAY_RECIP  = MUL_B_W'(50903317);  // 2^35 / 675
	localparam logic [MUL_B_W-1:0] HOUR_RECIP = MUL_B_W'(9321);      // 2^21 / 225
	localparam logic [MUL_B_W-1:0] MIN_RECIP  = MUL_B_W'(1093);      // 2^14 / 15
	localparam logic [MUL_B_W-1:0] DAY_SECS   = MUL_B_W'(86400);
	localparam logic [MUL_B_W-1:0] HOUR_SECS  = MUL_B_W'(3600);
	localparam logic [MUL_B_W-1:0] MIN_SECS   = MUL_B_W'(60);

	localparam logic [SUB_W-1:0]  DAYS_YEAR    = SUB_W'(365);
	localparam logic [SUB_W-1:0]  DAYS_LEAP    = SUB_W'(366);
	localparam logic [YEAR_W-1:0] FIRST_YEAR   = YEAR_W'(1970);
	localparam logic [6:0]        FIRST_MOD100 = 7'd70;
	localparam logic [8:0]        FIRST_MOD400 = 9'd370;
	localparam logic [6:0]        LAST_MOD100  = 7'd99;
	localparam logic [8:0]        LAST_MOD400  = 9'd399;

	typedef struct packed {
		logic [SUB_W-1:0] diff;
		logic             borrow;  // a < b
	} sub_res_t;

	typedef struct packed {
		logic clear;  // load 1970
		logic incr;   // step one year
	} yr_ctl_t;

endpackage

>>> sv/epoch_seconds_to_year_time.sv
// Top level: epoch seconds to Gregorian year and time of day.
// Depends on ep2y_pkg, ep2y_sub, ep2y_yearctr.
//
//  channel | handshake      | word
//  --------+----------------+------------------------------------------
//  input   | start & !busy  | epoch_seconds[31:0]
//  result  | done (1 cycle) | year[11:0] hour[4:0] minute[5:0]
//          |                | second_of_minute[5:0]
//
// A word steps through the load, the day quotient, the time of day, the year walk
// from 1970 (one year per step, plus a final step that ends it), the hour quotient and
// remainder, the minute quotient and remainder, and the done state.
// Quotients come from the shared multiplier, remainders and the year walk from the
// shared subtractor. busy stays high until the done cycle ends.
// arst_n clears the sequencer; the receiver cannot stall the done strobe.
module epoch_seconds_to_year_time
	import ep2y_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [31:0]       epoch_seconds,
	output logic              done,
	output logic [YEAR_W-1:0] year,
	output logic [4:0]        hour,
	output logic [5:0]        minute,
	output logic [5:0]        second_of_minute
);

	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_DAYQ  = 9'b000000010,
		ST_TOD   = 9'b000000100,
		ST_YEARS = 9'b000001000,
		ST_HOURQ = 9'b000010000,
		ST_HOURR = 9'b000100000,
		ST_MINQ  = 9'b001000000,
		ST_MINR  = 9'b010000000,
		ST_DONE  = 9'b100000000
	} state_t;

	state_t             state_q;
	logic [31:0]        sec_q;
	logic [SUB_W-1:0]   rem_q;
	logic [DAYS_W-1:0]  days_q;
	logic [4:0]         hour_q;
	logic [5:0]         min_q;

	logic [MUL_A_W-1:0] mul_a;
	logic [MUL_B_W-1:0] mul_b;
	logic [MUL_P_W-1:0] prod;
	logic [SUB_W-1:0]   op_a;
	logic [SUB_W-1:0]   op_b;
	sub_res_t           sub;
	yr_ctl_t            yr_ctl;
	logic               leap;

	// quotient by reciprocal, then quotient times divisor for the remainder
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_DAYQ: begin
				mul_a = sec_q[31:7];
				mul_b = DAY_RECIP;
			end
			ST_TOD: begin
				mul_a = {{(MUL_A_W-DAYS_W){1'b0}}, days_q};
				mul_b = DAY_SECS;
			end
			ST_HOURQ: begin
				mul_a = {{(MUL_A_W-13){1'b0}}, rem_q[16:4]};
				mul_b = HOUR_RECIP;
			end
			ST_HOURR: begin
				mul_a = {{(MUL_A_W-5){1'b0}}, hour_q};
				mul_b = HOUR_SECS;
			end
			ST_MINQ: begin
				mul_a = {{(MUL_A_W-10){1'b0}}, rem_q[11:2]};
				mul_b = MIN_RECIP;
			end
			ST_MINR: begin
				mul_a = {{(MUL_A_W-6){1'b0}}, min_q};
				mul_b = MIN_SECS;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod = {{MUL_B_W{1'b0}}, mul_a} * {{MUL_A_W{1'b0}}, mul_b};

	// remainders are below 2^SUB_W, so the low product bits are enough
	always_comb begin
		op_a = rem_q;
		op_b = prod[SUB_W-1:0];
		case (state_q)
			ST_TOD: begin
				op_a = sec_q[SUB_W-1:0];
				op_b = prod[SUB_W-1:0];
			end
			ST_YEARS: begin
				op_a = {{(SUB_W-DAYS_W){1'b0}}, days_q};
				op_b = leap ? DAYS_LEAP : DAYS_YEAR;
			end
			default: begin
				op_a = rem_q;
				op_b = prod[SUB_W-1:0];
			end
		endcase
	end

	ep2y_sub u_sub (
		.a   (op_a),
		.b   (op_b),
		.res (sub)
	);

	assign yr_ctl.clear = (state_q == ST_IDLE) && start;
	assign yr_ctl.incr  = (state_q == ST_YEARS) && !sub.borrow;

	ep2y_yearctr u_year (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (yr_ctl),
		.year   (year),
		.leap   (leap)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_DAYQ;
					end
				end
				ST_DAYQ: begin
					state_q <= ST_TOD;
				end
				ST_TOD: begin
					state_q <= ST_YEARS;
				end
				ST_YEARS: begin
					if (sub.borrow) begin
						state_q <= ST_HOURQ;
					end
				end
				ST_HOURQ: begin
					state_q <= ST_HOURR;
				end
				ST_HOURR: begin
					state_q <= ST_MINQ;
				end
				ST_MINQ: begin
					state_q <= ST_MINR;
				end
				ST_MINR: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath: seconds, remainder, quotient and digit registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					sec_q <= epoch_seconds;
				end
			end
			ST_DAYQ: begin
				days_q <= prod[DAY_SHIFT +: DAYS_W];
			end
			ST_TOD: begin
				rem_q <= sub.diff;
			end
			ST_YEARS: begin
				if (!sub.borrow) begin
					days_q <= sub.diff[DAYS_W-1:0];
				end
			end
			ST_HOURQ: begin
				hour_q <= prod[HOUR_SHIFT +: 5];
			end
			ST_HOURR: begin
				rem_q <= sub.diff;
			end
			ST_MINQ: begin
				min_q <= prod[MIN_SHIFT +: 6];
			end
			ST_MINR: begin
				rem_q <= sub.diff;
			end
			default: begin
				sec_q <= sec_q;
			end
		endcase
	end

	assign busy             = (state_q != ST_IDLE);
	assign done             = (state_q == ST_DONE);
	assign hour             = hour_q;
	assign minute           = min_q;
	assign second_of_minute = rem_q[5:0];

endmodule

>>> sv/ep2y_sub.sv
// Shared compare/subtract unit of the converter: a - b with borrow.
// Depends on ep2y_pkg.
module ep2y_sub
	import ep2y_pkg::*;
(
	input  logic [SUB_W-1:0] a,
	input  logic [SUB_W-1:0] b,
	output sub_res_t         res
);

	logic [SUB_W:0] wide;

	assign wide       = {1'b0, a} - {1'b0, b};
	assign res.diff   = wide[SUB_W-1:0];
	assign res.borrow = wide[SUB_W];

endmodule

>>> sv/ep2y_yearctr.sv
// Year counter with running mod-100 and mod-400 residues for the leap rule.
// Depends on ep2y_pkg.
module ep2y_yearctr
	import ep2y_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  yr_ctl_t           ctl,
	output logic [YEAR_W-1:0] year,
	output logic              leap
);

	logic [YEAR_W-1:0] year_q;
	logic [6:0]        mod100_q;
	logic [8:0]        mod400_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			year_q   <= FIRST_YEAR;
			mod100_q <= FIRST_MOD100;
			mod400_q <= FIRST_MOD400;
		end else if (ctl.clear) begin
			year_q   <= FIRST_YEAR;
			mod100_q <= FIRST_MOD100;
			mod400_q <= FIRST_MOD400;
		end else if (ctl.incr) begin
			year_q   <= year_q + YEAR_W'(1);
			mod100_q <= (mod100_q == LAST_MOD100) ? 7'd0 : mod100_q + 7'd1;
			mod400_q <= (mod400_q == LAST_MOD400) ? 9'd0 : mod400_q + 9'd1;
		end
	end

	assign year = year_q;
	assign leap = (year_q[1:0] == 2'b00) && ((mod100_q != 7'd0) || (mod400_q == 9'd0));

endmodule

>>> tb/sv/testbench.sv
// Testbench for epoch_seconds_to_year_time: a scoreboard class with its own
// calendar predictor checks every done word against the accepted inputs.
// Depends on ep2y_pkg and the epoch_seconds_to_year_time RTL.
module testbench;
	import ep2y_pkg::*;

	localparam int LIMIT_CYCLES = 1000000;
	localparam int DRAIN_CYCLES = 200;  // longer than the worst-case conversion
	localparam int LONG_GAP     = 190;

	typedef struct packed {
		logic [YEAR_W-1:0] year;
		logic [4:0]        hour;
		logic [5:0]        minute;
		logic [5:0]        second_of_minute;
	} year_time_t;

	class year_time_board;
		year_time_t pending[$];
		int         errors;

		static function bit is_leap_year(int unsigned y);
			return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
		endfunction

		// Walk whole days forward from 1970, one year length at a time.
		static function year_time_t calendar_of(logic [31:0] secs);
			int unsigned days, tod, yr, len;
			year_time_t r;
			days = secs / 86400;
			tod  = secs % 86400;
			yr   = 1970;
			len  = is_leap_year(yr) ? 366 : 365;
			while (days >= len) begin
				days -= len;
				yr++;
				len = is_leap_year(yr) ? 366 : 365;
			end
			r.year             = YEAR_W'(yr);
			r.hour             = 5'(tod / 3600);
			r.minute           = 6'((tod % 3600) / 60);
			r.second_of_minute = 6'(tod % 60);
			return r;
		endfunction

		function void note_word(logic [31:0] secs);
			pending.push_back(calendar_of(secs));
		endfunction

		function void check_word(year_time_t got);
			year_time_t want;
			if (pending.size() == 0) begin
				$display("%0t: done with no word pending: year %0d %0d:%0d:%0d", $time,
					got.year, got.hour, got.minute, got.second_of_minute);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.year !== want.year) begin
				$display("%0t: year expected %0d actual %0d", $time, want.year, got.year);
				errors++;
			end
			if (got.hour !== want.hour) begin
				$display("%0t: hour expected %0d actual %0d", $time, want.hour, got.hour);
				errors++;
			end
			if (got.minute !== want.minute) begin
				$display("%0t: minute expected %0d actual %0d", $time,
					want.minute, got.minute);
				errors++;
			end
			if (got.second_of_minute !== want.second_of_minute) begin
				$display("%0t: second expected %0d actual %0d", $time,
					want.second_of_minute, got.second_of_minute);
				errors++;
			end
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic [31:0]       epoch_seconds = '0;
	logic              busy;
	logic              done;
	logic [YEAR_W-1:0] year;
	logic [4:0]        hour;
	logic [5:0]        minute;
	logic [5:0]        second_of_minute;

	year_time_board board = new();
	longint unsigned year_start[$];
	int unsigned cycles = 0;

	epoch_seconds_to_year_time u_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.busy             (busy),
		.epoch_seconds    (epoch_seconds),
		.done             (done),
		.year             (year),
		.hour             (hour),
		.minute           (minute),
		.second_of_minute (second_of_minute)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Sampled at the edge, before any update of this step lands.
	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				board.check_word('{year, hour, minute, second_of_minute});
			if (start && !busy)
				board.note_word(epoch_seconds);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Holds start high until the word is taken; start stays high afterwards.
	task automatic send_word(logic [31:0] secs);
		epoch_seconds <= secs;
		start         <= 1'b1;
		do
			@(posedge clk);
		while (busy);
	endtask

	task automatic maybe_idle(int unsigned pct);
		if ($urandom_range(99) < pct) begin
			start <= 1'b0;
			if ($urandom_range(9) == 0)
				repeat ($urandom_range(1, LONG_GAP)) @(posedge clk);
			else
				repeat ($urandom_range(1, 30)) @(posedge clk);
		end
	endtask

	function automatic logic [31:0] random_secs();
		longint signed v;
		case ($urandom_range(9))
			0, 1, 2, 3: return $urandom();
			4, 5, 6: begin
				// around a year change, either side
				v = longint'(year_start[$urandom_range(year_start.size() - 1)])
					+ longint'($urandom_range(4 * 86400)) - 2 * 86400;
				if (v < 0 || v > 64'hFFFF_FFFF)
					return $urandom();
				return 32'(v);
			end
			7: return $urandom_range(3 * 86400);
			8: return 32'($urandom_range(49710) * 86400 + 86399);
			default: return 32'hFFFF_FFFF - $urandom_range(400 * 86400);
		endcase
	endfunction

	initial begin
		logic [31:0] directed[$];
		longint unsigned acc;
		int unsigned pct;

		acc = 0;
		for (int unsigned y = 1970; y <= 2106; y++) begin
			year_start.push_back(acc);
			acc += year_time_board::is_leap_year(y) ? 366 * 86400 : 365 * 86400;
		end

		directed = '{
			32'd0, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399, 32'd86400,
			32'd31535999, 32'd31536000,
			// 1972 is leap: its last day stays in 1972
			32'd94608000, 32'd94694399, 32'd94694400,
			// 2000 is leap by the 400 rule
			32'd946684800, 32'd978220800, 32'd978307199, 32'd978307200,
			// 2100 is not leap
			32'd4133894400, 32'd4133980799, 32'd4133980800,
			32'h7FFF_FFFF, 32'h8000_0000, 32'hAAAA_AAAA, 32'h5555_5555,
			32'd4291747200, 32'hFFFF_FFFF
		};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i])
			send_word(directed[i]);

		for (int ph = 0; ph < 3; ph++) begin
			pct = (ph == 0) ? 11 : (ph == 1) ? 80 : 0;
			for (int n = 0; n < 260; n++) begin
				send_word(random_secs());
				maybe_idle(pct);
			end
		end
		start <= 1'b0;

		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (board.errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
